// ----- src/tee_pkg.sv -----
`timescale 1ns / 1ps

package tee_pkg;

   typedef enum logic [1:0] {
      MODE_JSON = 2'd0,
      MODE_HTML = 2'd1,
      MODE_SQL  = 2'd2,
      MODE_RSVD = 2'd3
   } mode_type;

   localparam int SEQ_MAX     = 6;
   localparam int LEN_W       = $clog2(SEQ_MAX + 1);
   localparam int IDX_W       = $clog2(SEQ_MAX);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_ADDR_W-3:0] REG_ESCAPE_MODE = '0;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       string_end;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       string_end_out;
   } rsp_type;

   typedef struct packed {
      logic [SEQ_MAX-1:0][7:0] seq;
      logic [LEN_W-1:0]        len;
      logic                    str_end;
   } esc_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic full;
      logic empty;
   } qctl_type;

endpackage

// ----- src/text_escape_engine_top.sv -----
`timescale 1ns / 1ps

// text escaper: each byte pushed comes out as its escaped run of one to six
// bytes (json, html or sql rules, picked by the escape_mode register at
// address 0; the reserved mode passes bytes unchanged), one result beat per
// cycle while the receiver pops, the final beat of a run carrying run_last
// and the string end mark. plain text flows at one byte per clock while the
// receiver pops; a byte that expands to n bytes holds the output until all n
// are popped, and the two-entry queue between the classifier and the emitter
// fills and raises full while the run drains. a pushed byte goes into the
// queue, then into the registered output beat, before it reaches the result
// ports. change escape_mode only while nothing is in flight.
module text_escape_engine_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   output logic                               full,
   input  tee_pkg::req_type                   req_data,
   output logic                               empty,
   input  logic                               pop,
   output tee_pkg::rsp_type                   rsp_data,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [tee_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [tee_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [tee_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready
);
   import tee_pkg::*;

   mode_type mode_ff, mode_in;
   esc_type  esc, head;
   qctl_type qctl;
   logic     head_done;
   logic     csr_hit;

   assign pready  = 1'b1;
   assign csr_hit = (paddr[CSR_ADDR_W-1:2] == REG_ESCAPE_MODE);
   assign prdata  = csr_hit ? {{(CSR_DATA_W-2){1'b0}}, mode_ff} : '0;

   always_comb begin
      mode_in = mode_ff;
      if (psel && penable && pwrite && pready && csr_hit) begin
         mode_in = mode_type'(pwdata[1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_JSON;
      end else begin
         mode_ff <= mode_in;
      end
   end

   tee_front u_front (
      .mode     (mode_ff),
      .req_data (req_data),
      .esc      (esc)
   );

   tee_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_data (esc),
      .rd_data (head),
      .push_in (push),
      .pop_in  (head_done),
      .qctl    (qctl)
   );

   assign full = qctl.full;

   tee_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (!qctl.empty),
      .head_done  (head_done),
      .rsp_data   (rsp_data),
      .empty      (empty),
      .pop        (pop)
   );

endmodule

// ----- src/tee_front.sv -----
`timescale 1ns / 1ps

module tee_front (
   input  tee_pkg::mode_type mode,
   input  tee_pkg::req_type  req_data,
   output tee_pkg::esc_type  esc
);
   import tee_pkg::*;

   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_DQ    = 8'h22;
   localparam logic [7:0] CH_SQ    = 8'h27;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_SUB   = 8'h1A;
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] r;
      if (nib < 4'd10) begin
         r = 8'h30 + {4'd0, nib};
      end else begin
         r = 8'h57 + {4'd0, nib};
      end
      return r;
   endfunction

   logic [7:0] c;

   assign c = req_data.in_byte;

   always_comb begin
      esc         = '0;
      esc.str_end = req_data.string_end;
      esc.seq[0]  = c;
      esc.len     = LEN_W'(1);
      case (mode)
         MODE_JSON: begin
            if (c == CH_DQ || c == CH_BSL) begin
               esc.seq[0] = CH_BSL; esc.seq[1] = c; esc.len = LEN_W'(2);
            end else if (c == CH_BS) begin
               esc.seq[0] = CH_BSL; esc.seq[1] = "b"; esc.len = LEN_W'(2);
            end else if (c == CH_FF) begin
               esc.seq[0] = CH_BSL; esc.seq[1] = "f"; esc.len = LEN_W'(2);
            end else if (c == CH_LF) begin
               esc.seq[0] = CH_BSL; esc.seq[1] = "n"; esc.len = LEN_W'(2);
            end else if (c == CH_CR) begin
               esc.seq[0] = CH_BSL; esc.seq[1] = "r"; esc.len = LEN_W'(2);
            end else if (c == CH_TAB) begin
               esc.seq[0] = CH_BSL; esc.seq[1] = "t"; esc.len = LEN_W'(2);
            end else if (c < CH_SPACE) begin
               esc.seq[0] = CH_BSL;
               esc.seq[1] = "u";
               esc.seq[2] = CH_ZERO;
               esc.seq[3] = CH_ZERO;
               esc.seq[4] = hex_char(c[7:4]);
               esc.seq[5] = hex_char(c[3:0]);
               esc.len    = LEN_W'(6);
            end
         end
         MODE_HTML: begin
            if (c == CH_AMP) begin
               esc.seq[0] = CH_AMP; esc.seq[1] = "a"; esc.seq[2] = "m";
               esc.seq[3] = "p";    esc.seq[4] = CH_SEMI;
               esc.len    = LEN_W'(5);
            end else if (c == CH_LT) begin
               esc.seq[0] = CH_AMP; esc.seq[1] = "l"; esc.seq[2] = "t";
               esc.seq[3] = CH_SEMI;
               esc.len    = LEN_W'(4);
            end else if (c == CH_GT) begin
               esc.seq[0] = CH_AMP; esc.seq[1] = "g"; esc.seq[2] = "t";
               esc.seq[3] = CH_SEMI;
               esc.len    = LEN_W'(4);
            end else if (c == CH_DQ) begin
               esc.seq[0] = CH_AMP; esc.seq[1] = "q"; esc.seq[2] = "u";
               esc.seq[3] = "o";    esc.seq[4] = "t"; esc.seq[5] = CH_SEMI;
               esc.len    = LEN_W'(6);
            end else if (c == CH_SQ) begin
               esc.seq[0] = CH_AMP; esc.seq[1] = CH_HASH; esc.seq[2] = "x";
               esc.seq[3] = "2";    esc.seq[4] = "7";     esc.seq[5] = CH_SEMI;
               esc.len    = LEN_W'(6);
            end
         end
         MODE_SQL: begin
            if (c == CH_SQ) begin
               esc.seq[0] = CH_SQ; esc.seq[1] = CH_SQ; esc.len = LEN_W'(2);
            end else if (c == CH_DQ || c == CH_BSL) begin
               esc.seq[0] = CH_BSL; esc.seq[1] = c; esc.len = LEN_W'(2);
            end else if (c == CH_NUL) begin
               esc.seq[0] = CH_BSL; esc.seq[1] = CH_ZERO; esc.len = LEN_W'(2);
            end else if (c == CH_SUB) begin
               esc.seq[0] = CH_BSL; esc.seq[1] = "Z"; esc.len = LEN_W'(2);
            end
         end
         default: begin
            esc.seq[0] = c;
            esc.len    = LEN_W'(1);
         end
      endcase
   end

endmodule

// ----- src/tee_queue.sv -----
`timescale 1ns / 1ps

module tee_queue (
   input  logic             clock,
   input  logic             reset,
   input  tee_pkg::esc_type wr_data,
   output tee_pkg::esc_type rd_data,
   input  logic             push_in,
   input  logic             pop_in,
   output tee_pkg::qctl_type qctl
);
   import tee_pkg::*;

   esc_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign qctl.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign qctl.empty = (count_ff == '0);
   assign qctl.push  = do_push;
   assign qctl.pop   = do_pop;
   assign do_push    = push_in && !qctl.full;
   assign do_pop     = pop_in && !qctl.empty;
   assign rd_data    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      do_push && !do_pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count missed a write");

   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (qctl.empty || qctl.full) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers out of step with count");

endmodule

// ----- src/tee_back.sv -----
`timescale 1ns / 1ps

module tee_back (
   input  logic             clock,
   input  logic             reset,
   input  tee_pkg::esc_type head,
   input  logic             head_valid,
   output logic             head_done,
   output tee_pkg::rsp_type rsp_data,
   output logic             empty,
   input  logic             pop
);
   import tee_pkg::*;

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             valid_ff, valid_in;
   rsp_type          rsp_ff, rsp_in;
   logic             load, is_last;

   assign load      = head_valid && (!valid_ff || pop);
   assign is_last   = (LEN_W'(idx_ff) + 1'b1) == head.len;
   assign head_done = load && is_last;
   assign rsp_data  = rsp_ff;
   assign empty     = !valid_ff;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      rsp_in   = rsp_ff;
      if (load) begin
         valid_in              = 1'b1;
         rsp_in.out_byte       = head.seq[idx_ff];
         rsp_in.run_last       = is_last;
         rsp_in.string_end_out = is_last && head.str_end;
         idx_in                = is_last ? '0 : idx_ff + 1'b1;
      end else if (pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   a_end_on_last: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !rsp_ff.run_last |-> !rsp_ff.string_end_out)
      else $error("string end flagged before last beat of run");

   a_idx_in_run: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> LEN_W'(idx_ff) < head.len)
      else $error("byte index past run length");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !pop |=> valid_ff && $stable(rsp_ff))
      else $error("stalled result beat changed");

endmodule

// ----- dv/escape_checker.sv -----
`timescale 1ns / 1ps

module escape_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  logic                           full,
   input  tee_pkg::req_type               req_data,
   input  logic                           empty,
   input  logic                           pop,
   input  tee_pkg::rsp_type               rsp_data,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [tee_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [tee_pkg::CSR_DATA_W-1:0] pwdata,
   input  logic [tee_pkg::CSR_DATA_W-1:0] prdata,
   input  logic                           pready,
   output int                             mismatches,
   output int                             pending,
   output int                             bytes_in,
   output int                             beats_out
);
   import tee_pkg::*;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_BS     = 8'h08;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_FF     = 8'h0C;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SUB    = 8'h1A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_AMP    = 8'h26;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_BSLASH = 8'h5C;

   mode_type  escape_mode;
   rsp_type   expected_beats [$];

   function automatic logic [7:0] hex_digit(input logic [3:0] v);
      return (v < 4'd10) ? 8'h30 + 8'(v) : 8'h61 + 8'(v) - 8'd10;
   endfunction

   // queue every beat that one byte expands to under the given mode
   task automatic predict_escape(input mode_type mode, input req_type r);
      logic [47:0] word;
      int          n;
      rsp_type     beat;
      logic [7:0]  c;
      c = r.in_byte;
      word = {40'd0, c};
      n = 1;
      case (mode)
         MODE_JSON: begin
            case (c)
               CH_DQUOTE, CH_BSLASH: begin word = {32'd0, CH_BSLASH, c}; n = 2; end
               CH_BS:  begin word = {32'd0, CH_BSLASH, "b"}; n = 2; end
               CH_FF:  begin word = {32'd0, CH_BSLASH, "f"}; n = 2; end
               CH_LF:  begin word = {32'd0, CH_BSLASH, "n"}; n = 2; end
               CH_CR:  begin word = {32'd0, CH_BSLASH, "r"}; n = 2; end
               CH_TAB: begin word = {32'd0, CH_BSLASH, "t"}; n = 2; end
               default: begin
                  if (c < CH_SPACE) begin
                     word = {CH_BSLASH, "u00", hex_digit(c[7:4]), hex_digit(c[3:0])};
                     n = 6;
                  end
               end
            endcase
         end
         MODE_HTML: begin
            case (c)
               CH_AMP:    begin word = {8'd0, "&amp;"};  n = 5; end
               CH_LT:     begin word = {16'd0, "&lt;"};  n = 4; end
               CH_GT:     begin word = {16'd0, "&gt;"};  n = 4; end
               CH_DQUOTE: begin word = "&quot;";         n = 6; end
               CH_SQUOTE: begin word = "&#x27;";         n = 6; end
               default: ;
            endcase
         end
         MODE_SQL: begin
            case (c)
               CH_SQUOTE:            begin word = {32'd0, CH_SQUOTE, CH_SQUOTE}; n = 2; end
               CH_DQUOTE, CH_BSLASH: begin word = {32'd0, CH_BSLASH, c};         n = 2; end
               CH_NUL:               begin word = {32'd0, CH_BSLASH, "0"};       n = 2; end
               CH_SUB:               begin word = {32'd0, CH_BSLASH, "Z"};       n = 2; end
               default: ;
            endcase
         end
         default: ;
      endcase
      for (int k = 0; k < n; k++) begin
         beat.out_byte       = word[8*(n-1-k) +: 8];
         beat.run_last       = (k == n - 1);
         beat.string_end_out = (k == n - 1) && r.string_end;
         expected_beats.push_back(beat);
      end
   endtask

   task automatic report(input string what, input logic [31:0] exp_v, input logic [31:0] got_v);
      if (mismatches < 10)
         $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, exp_v, got_v);
      mismatches++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         escape_mode = MODE_JSON;
         expected_beats.delete();
         mismatches = 0;
         bytes_in   <= 0;
         beats_out  <= 0;
         pending    <= 0;
      end else begin
         if (psel && penable && pready && paddr[CSR_ADDR_W-1:2] == REG_ESCAPE_MODE) begin
            if (pwrite)
               escape_mode = mode_type'(pwdata[1:0]);
            else if (prdata !== CSR_DATA_W'(escape_mode))
               report("escape_mode readback", CSR_DATA_W'(escape_mode), prdata);
         end
         if (push && !full) begin
            predict_escape(escape_mode, req_data);
            bytes_in <= bytes_in + 1;
         end
         if (pop && !empty) begin
            beats_out <= beats_out + 1;
            if (expected_beats.size() == 0) begin
               report("unexpected beat", '0, 32'(rsp_data));
            end else begin
               want = expected_beats.pop_front();
               if (rsp_data.out_byte !== want.out_byte)
                  report("out_byte", 32'(want.out_byte), 32'(rsp_data.out_byte));
               if (rsp_data.run_last !== want.run_last)
                  report("run_last", 32'(want.run_last), 32'(rsp_data.run_last));
               if (rsp_data.string_end_out !== want.string_end_out)
                  report("string_end_out", 32'(want.string_end_out),
                         32'(rsp_data.string_end_out));
            end
         end
         pending <= expected_beats.size();
      end
   end

endmodule

// ----- dv/text_escape_engine_top_test.sv -----
`timescale 1ns / 1ps

module text_escape_engine_top_test;
   import tee_pkg::*;

   localparam int                    IDLE_LIMIT = 2000;
   localparam logic [CSR_ADDR_W-3:0] REG_UNUSED = (CSR_ADDR_W-2)'(1);

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  push;
   logic                  full;
   req_type               req_data;
   logic                  empty;
   logic                  pop;
   rsp_type               rsp_data;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int   mismatches;
   int   pending;
   int   bytes_in;
   int   beats_out;
   int   idle_cycles;
   int   mode_settings;
   logic feed_idle;
   logic drain_idle;

   text_escape_engine_top dut (
      .clock(clock), .reset(reset),
      .push(push), .full(full), .req_data(req_data),
      .empty(empty), .pop(pop), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   escape_checker checker_i (
      .clock(clock), .reset(reset),
      .push(push), .full(full), .req_data(req_data),
      .empty(empty), .pop(pop), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready),
      .mismatches(mismatches), .pending(pending),
      .bytes_in(bytes_in), .beats_out(beats_out)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || (psel && penable)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("text_escape_engine_top_test failed");
            $finish;
         end
      end
   end

   // receiver: random stall before each beat while drain_idle is set
   initial begin
      int gap;
      pop = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = drain_idle ? $urandom_range(0, 12) : 0;
         if (gap > 0) begin
            pop = 1'b0;
            repeat (gap) @(negedge clock);
         end
         pop = 1'b1;
         do @(posedge clock); while (empty);
         @(negedge clock);
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = feed_idle ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
         push = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data.in_byte    = b;
      req_data.string_end = last;
      push = 1'b1;
      do @(posedge clock); while (full);
      @(negedge clock);
   endtask

   task automatic drain();
      push = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [CSR_ADDR_W-3:0] index,
                             input logic [CSR_DATA_W-1:0] data);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = wr;
      paddr   = {index, 2'b00};
      pwdata  = data;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   // upper bits of the write are junk and must be dropped
   task automatic set_mode(input mode_type m);
      drain();
      csr_access(1'b1, REG_ESCAPE_MODE, {(CSR_DATA_W-2)'($urandom), m});
      csr_access(1'b0, REG_ESCAPE_MODE, '0);
      mode_settings++;
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 3))
         0, 1: return 8'($urandom);
         2:    return 8'($urandom_range(0, 31));
         default: begin
            case ($urandom_range(0, 12))
               0:  return 8'h22;
               1:  return 8'h5C;
               2:  return 8'h08;
               3:  return 8'h0C;
               4:  return 8'h0A;
               5:  return 8'h0D;
               6:  return 8'h09;
               7:  return 8'h26;
               8:  return 8'h3C;
               9:  return 8'h3E;
               10: return 8'h27;
               11: return 8'h00;
               default: return 8'h1A;
            endcase
         end
      endcase
   endfunction

   initial begin
      mode_type phase_mode;
      int       sent;
      int       len;
      reset      = 1'b1;
      push       = 1'b0;
      req_data   = '0;
      psel       = 1'b0;
      penable    = 1'b0;
      pwrite     = 1'b0;
      paddr      = '0;
      pwdata     = '0;
      feed_idle  = 1'b1;
      drain_idle = 1'b1;
      mode_settings = 1;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // json under the reset mode
      csr_access(1'b0, REG_ESCAPE_MODE, '0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h1F, 1'b0);
      send_byte(8'h08, 1'b0);
      send_byte(8'h0C, 1'b1);
      send_byte(8'h0A, 1'b0);
      send_byte(8'h0D, 1'b0);
      send_byte(8'h09, 1'b0);
      send_byte(8'h22, 1'b0);
      send_byte(8'h5C, 1'b1);
      send_byte(8'h7F, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h20, 1'b1);

      // write to an unmapped index is dropped
      drain();
      csr_access(1'b1, REG_UNUSED, 32'hFFFF_FFFF);
      csr_access(1'b0, REG_ESCAPE_MODE, '0);

      set_mode(MODE_HTML);
      send_byte(8'h26, 1'b0);
      send_byte(8'h3C, 1'b0);
      send_byte(8'h3E, 1'b1);
      send_byte(8'h22, 1'b0);
      send_byte(8'h27, 1'b1);

      set_mode(MODE_SQL);
      send_byte(8'h27, 1'b0);
      send_byte(8'h22, 1'b0);
      send_byte(8'h5C, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h1A, 1'b1);

      set_mode(MODE_RSVD);
      send_byte(8'h22, 1'b1);

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: phase_mode = MODE_JSON;
            1: phase_mode = MODE_HTML;
            2: phase_mode = MODE_SQL;
            3: phase_mode = MODE_RSVD;
            default: phase_mode = mode_type'($urandom_range(0, 3));
         endcase
         set_mode(phase_mode);
         feed_idle  = (ph != 0) && ($urandom_range(0, 3) != 0);
         drain_idle = (ph != 0) && ($urandom_range(0, 3) != 0);
         sent = 0;
         while (sent < 18) begin
            len = $urandom_range(1, 8);
            for (int j = 0; j < len; j++) begin
               send_byte(pick_byte(), j == len - 1);
               sent++;
               // sender holds off until the output side is fully drained
               if (ph == 1 && sent == 12) begin
                  push = 1'b0;
                  while (pending != 0) @(negedge clock);
               end
            end
         end
      end

      push = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);

      $display("run covered %0d input bytes and %0d escaped beats over %0d mode settings",
               bytes_in, beats_out, mode_settings);
      $display("json, html, sql and the unused mode each saw control, quote and plain bytes");
      if (mismatches == 0) begin
         $display("text_escape_engine_top_test passed");
      end else begin
         $display("text_escape_engine_top_test failed");
      end
      $finish;
   end

endmodule
